[sv/ils_pkg.sv]
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the integer LIFO stack: request and result
// payloads, operation and status codes, default depth.
// ----------------------------------------------------------------------------
package ils_pkg;

	localparam int unsigned DEPTH_DEFAULT = 256;
	localparam int unsigned CAP_W         = 9;
	localparam int unsigned COUNT_OUT_W   = 9;
	localparam int unsigned INDEX_OUT_W   = 8;

	// operation codes
	localparam logic [2:0] OP_PUSH   = 3'd0;
	localparam logic [2:0] OP_POP    = 3'd1;
	localparam logic [2:0] OP_PEEK   = 3'd2;
	localparam logic [2:0] OP_CLEAR  = 3'd3;
	localparam logic [2:0] OP_SEARCH = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] value;
	} ils_in_t;

	typedef struct packed {
		logic [1:0]                 status;
		logic signed [31:0]         data_out;
		logic [INDEX_OUT_W-1:0]     found_index;
		logic [COUNT_OUT_W-1:0]     entry_count;
		logic                       is_empty;
		logic                       is_full;
	} ils_out_t;

endpackage

[sv/ils_engine.sv]
// ----------------------------------------------------------------------------
// ils_engine
// Stack storage and sequencer. One memory port pair serves push, pop, peek
// and search; search walks the live entries one a cycle on a 32-bit compare.
// ----------------------------------------------------------------------------
module ils_engine import ils_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  ils_in_t          req,
	input  logic [CAP_W-1:0] capacity,
	input  logic             cap_is_depth,
	output logic             ready,
	output logic             res_valid,
	output ils_out_t         res,
	input  logic             res_take
);

	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_RDATA = 5'b00100,
		S_SCAN  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [2:0]         op_q;
	logic signed [31:0] value_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	logic [1:0]         status_q;
	logic signed [31:0] data_q;
	logic [AW-1:0]      found_q;

	logic [31:0]        mem [DEPTH];
	logic [31:0]        rd_data_q;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;

	logic [CMPW-1:0]    eff_cap;
	logic               full;
	logic               empty;
	logic               last_idx;

	// capacity above the depth acts as the depth; so does the reset capacity
	always_comb begin
		if (cap_is_depth || (CMPW'(capacity) > CMPW'(DEPTH))) begin
			eff_cap = CMPW'(DEPTH);
		end else begin
			eff_cap = CMPW'(capacity);
		end
	end

	assign full     = CMPW'(count_q) >= eff_cap;
	assign empty    = (count_q == '0);
	assign last_idx = (CW'(idx_q) + CW'(1)) >= count_q;

	assign ready     = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		unique case (state_q)
			S_EXEC: begin
				unique case (op_q) inside
					OP_PUSH: wr_en = !full;
					OP_POP, OP_PEEK: begin
						rd_en   = !empty;
						rd_addr = AW'(count_q - CW'(1));
					end
					OP_SEARCH: begin
						rd_en   = !empty;
						rd_addr = '0;
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = idx_q + AW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(count_q)] <= value_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q    <= req.operation;
			value_q <= req.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			status_q <= ST_OK;
			data_q   <= '0;
			found_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= ST_OK;
					data_q   <= '0;
					found_q  <= '0;
					idx_q    <= '0;
					state_q  <= S_DONE;
					unique case (op_q)
						OP_PUSH: begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						OP_POP: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else begin
								count_q <= count_q - CW'(1);
								state_q <= S_RDATA;
							end
						end
						OP_PEEK: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else begin
								state_q <= S_RDATA;
							end
						end
						OP_CLEAR: count_q <= '0;
						OP_SEARCH: begin
							if (empty) begin
								status_q <= ST_NOTFOUND;
							end else begin
								state_q <= S_SCAN;
							end
						end
						default: ;
					endcase
				end
				S_RDATA: begin
					data_q  <= rd_data_q;
					state_q <= S_DONE;
				end
				S_SCAN: begin
					// rd_data_q holds entry idx_q; next read is already issued
					if (rd_data_q == value_q) begin
						found_q <= idx_q;
						state_q <= S_DONE;
					end else if (last_idx) begin
						status_q <= ST_NOTFOUND;
						state_q  <= S_DONE;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		res.status      = status_q;
		res.data_out    = data_q;
		res.found_index = INDEX_OUT_W'(found_q);
		res.entry_count = COUNT_OUT_W'(count_q);
		res.is_empty    = empty;
		res.is_full     = full;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(count_q) <= CW'(DEPTH))
		else $error("entry count above depth");

	a_scan_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CW'(idx_q) < count_q))
		else $error("search beyond live entries");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && op_q == OP_PUSH && !full) |=>
		(count_q == $past(count_q) + CW'(1)))
		else $error("push did not advance count");

	a_take_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |-> (state_q == S_DONE))
		else $error("result taken while not done");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == S_EXEC))
		else $error("request not started");

endmodule

[sv/integer_lifo_stack.sv]
// ----------------------------------------------------------------------------
// integer_lifo_stack
// Bounded LIFO stack of 32-bit signed words with push, pop, peek, clear and
// search, a capacity register and a registered result stage.
//
//   channel  signals                          payload
//   in       in_valid, in_stall (driven)      in_data   : ils_in_t
//   out      out_valid, out_stall (received)  out_data  : ils_out_t
//   cfg      cfg_we                           cfg_wdata : capacity in use
//
// One request at a time. Push, clear, unknown codes and a pop, peek or
// search on an empty stack go from execute to done; pop and peek go through
// execute, read-data and done; search goes through execute, compares one
// entry per cycle in scan, then done. The single memory read port and the
// search compare shape these steps. in_stall is high from accept until the
// result moves into the output register; a stalled output holds the result
// and the next request may be accepted behind it. Reset empties the stack
// and sets the capacity to the depth; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module integer_lifo_stack import ils_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ils_in_t          in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output ils_out_t         out_data,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	localparam int unsigned CAP_MAX   = (1 << CAP_W) - 1;
	localparam int unsigned CAP_RESET = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;

	logic [CAP_W-1:0] cap_q;
	logic             cap_is_depth_q;
	logic             eng_ready;
	logic             eng_valid;
	ils_out_t         eng_res;
	logic             start;
	logic             res_take;
	logic             out_valid_q;
	ils_out_t         out_q;

	assign in_stall = !eng_ready;
	assign start    = in_valid && eng_ready;
	assign res_take = eng_valid && (!out_valid_q || !out_stall);

	// until the first write the capacity is the full depth, even if it
	// does not fit the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q          <= CAP_W'(CAP_RESET);
			cap_is_depth_q <= 1'b1;
		end else if (cfg_we) begin
			cap_q          <= cfg_wdata;
			cap_is_depth_q <= 1'b0;
		end
	end

	ils_engine #(
		.DEPTH(DEPTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req          (in_data),
		.capacity     (cap_q),
		.cap_is_depth (cap_is_depth_q),
		.ready        (eng_ready),
		.res_valid    (eng_valid),
		.res          (eng_res),
		.res_take     (res_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= eng_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[sim/tb_integer_lifo_stack.sv]
// ----------------------------------------------------------------------------
// tb_integer_lifo_stack
// Self-checking bench for the integer LIFO stack. A short table of directed
// requests covers the empty and full corners, the word extremes, every
// operation and the capacity corners. Random phases with push-heavy,
// pop-heavy and balanced mixes follow, each under its own capacity. A local
// shadow stack predicts each result. The sender runs in bursts and the
// receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_integer_lifo_stack;
	import ils_pkg::*;

	localparam int unsigned STACK_DEPTH    = DEPTH_DEFAULT;
	localparam int          DIRECTED_ROWS  = 29;
	localparam int          RANDOM_ITEMS   = 1525;
	localparam int          SETTLE_CYCLES  = 300;
	localparam int          WATCHDOG_LIMIT = 4000;

	// codes the block must ignore
	localparam logic [2:0] OP_RSVD_5 = 3'd5;
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;

	localparam logic [CAP_W-1:0] CAP_MAX  = '1;
	localparam logic [31:0]      WORD_MIN = 32'h8000_0000;
	localparam logic [31:0]      WORD_MAX = 32'h7fff_ffff;
	localparam logic [31:0]      ALL_ONES = 32'hffff_ffff;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} op_mix_t;
	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	typedef struct {
		bit               is_cfg;
		logic [CAP_W-1:0] capacity;
		ils_in_t          req;
		bit               typed;
		ils_out_t         result;
	} script_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	ils_in_t          in_data;
	logic             out_valid;
	logic             out_stall;
	ils_out_t         out_data;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	// shadow copy of the stack
	logic [31:0]      shadow_words [STACK_DEPTH];
	int unsigned      shadow_count;
	logic [CAP_W-1:0] shadow_capacity;

	ils_out_t    pending_results[$];
	int          issued_count;
	int          delivered_count;
	int          error_count;
	int          quiet_cycles;
	stall_mode_t stall_mode;
	int          stall_hold;
	logic [31:0] value_pool [8];
	script_row_t directed_script [DIRECTED_ROWS];

	integer_lifo_stack #(
		.DEPTH(STACK_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic ils_out_t apply_stack_op(input ils_in_t req);
		ils_out_t    res;
		int unsigned cap;
		int unsigned i;
		bit          hit;
		cap = (shadow_capacity > STACK_DEPTH) ? STACK_DEPTH : shadow_capacity;
		res = '0;
		res.status = ST_OK;
		hit = 1'b0;
		case (req.operation)
			OP_PUSH: begin
				if (shadow_count >= cap) begin
					res.status = ST_FULL;
				end else begin
					shadow_words[shadow_count] = req.value;
					shadow_count++;
				end
			end
			OP_POP: begin
				if (shadow_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					shadow_count--;
					res.data_out = shadow_words[shadow_count];
				end
			end
			OP_PEEK: begin
				if (shadow_count == 0)
					res.status = ST_EMPTY;
				else
					res.data_out = shadow_words[shadow_count - 1];
			end
			OP_CLEAR: shadow_count = 0;
			OP_SEARCH: begin
				res.status = ST_NOTFOUND;
				// bottom-up: lowest matching index wins
				for (i = 0; i < shadow_count && !hit; i++) begin
					if (shadow_words[i] == req.value) begin
						hit = 1'b1;
						res.status = ST_OK;
						res.found_index = INDEX_OUT_W'(i);
					end
				end
			end
			default: ;
		endcase
		res.entry_count = COUNT_OUT_W'(shadow_count);
		res.is_empty = (shadow_count == 0);
		res.is_full = (shadow_count >= cap);
		return res;
	endfunction

	function automatic script_row_t row_req(input logic [2:0] op, input logic [31:0] value);
		script_row_t r;
		r = '{default: '0};
		r.req.operation = op;
		r.req.value = value;
		return r;
	endfunction

	function automatic script_row_t row_chk(input logic [2:0] op, input logic [31:0] value,
			input logic [1:0] status, input logic [31:0] data, input logic [7:0] index,
			input logic [8:0] count, input logic empty, input logic full);
		script_row_t r;
		r = row_req(op, value);
		r.typed = 1'b1;
		r.result = '{status, data, index, count, empty, full};
		return r;
	endfunction

	function automatic script_row_t row_cap(input logic [CAP_W-1:0] capacity);
		script_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.capacity = capacity;
		return r;
	endfunction

	function automatic logic [2:0] pick_operation(input op_mix_t mix);
		int roll;
		int push_lim, pop_lim, peek_lim, search_lim, clear_lim;
		case (mix)
			MIX_FILL:  begin push_lim = 85; pop_lim = 90; peek_lim = 93; search_lim = 98; clear_lim = 98; end
			MIX_DRAIN: begin push_lim = 25; pop_lim = 70; peek_lim = 80; search_lim = 92; clear_lim = 95; end
			default:   begin push_lim = 40; pop_lim = 70; peek_lim = 78; search_lim = 92; clear_lim = 95; end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < push_lim)   return OP_PUSH;
		if (roll < pop_lim)    return OP_POP;
		if (roll < peek_lim)   return OP_PEEK;
		if (roll < search_lim) return OP_SEARCH;
		if (roll < clear_lim)  return OP_CLEAR;
		return OP_RSVD_5 + 3'($urandom_range(0, 2));
	endfunction

	function automatic logic [31:0] pick_value(input logic [2:0] op);
		int roll;
		roll = $urandom_range(0, 99);
		// searches often target a live entry so deep indexes get hit
		if (op == OP_SEARCH && shadow_count != 0 && roll < 40)
			return shadow_words[$urandom_range(0, shadow_count - 1)];
		if (roll < 60)
			return value_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	task automatic send_request(input ils_in_t req, input bit typed, input ils_out_t typed_result);
		ils_out_t predicted;
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall !== 1'b0);
		predicted = apply_stack_op(req);
		pending_results.push_back(typed ? typed_result : predicted);
		issued_count++;
	endtask

	// only while idle: drop valid, drain every result, then write
	task automatic write_capacity(input logic [CAP_W-1:0] capacity);
		in_valid <= 1'b0;
		do @(posedge clk); while (delivered_count < issued_count);
		cfg_we <= 1'b1;
		cfg_wdata <= capacity;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_capacity = capacity;
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : result_monitor
		ils_out_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: %p", out_data);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, out_data.status);
				check_field("data_out", want.data_out, out_data.data_out);
				check_field("found_index", want.found_index, out_data.found_index);
				check_field("entry_count", want.entry_count, out_data.entry_count);
				check_field("is_empty", want.is_empty, out_data.is_empty);
				check_field("is_full", want.is_full, out_data.is_full);
			end
			delivered_count <= delivered_count + 1;
		end
		if (stall_hold == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_hold = $urandom_range(32, 200);
		end else begin
			stall_hold--;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
			default:     out_stall <= ((stall_hold % 5) < 3);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("integer_lifo_stack verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int               phase_no;
		int               phase_len;
		int               k;
		int               burst_left;
		int               gap;
		int               random_items;
		logic [CAP_W-1:0] cap_now;
		op_mix_t          mix;
		ils_in_t          req;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		issued_count = 0;
		delivered_count = 0;
		error_count = 0;
		quiet_cycles = 0;
		stall_mode = STALL_NONE;
		stall_hold = 0;
		shadow_count = 0;
		shadow_capacity = CAP_W'(STACK_DEPTH);
		foreach (shadow_words[i])
			shadow_words[i] = '0;

		directed_script = '{
			row_chk(OP_POP,    0,        ST_EMPTY,    0,        0, 0, 1'b1, 1'b0),
			row_chk(OP_PEEK,   0,        ST_EMPTY,    0,        0, 0, 1'b1, 1'b0),
			row_chk(OP_SEARCH, 0,        ST_NOTFOUND, 0,        0, 0, 1'b1, 1'b0),
			row_chk(OP_PUSH,   WORD_MAX, ST_OK,       0,        0, 1, 1'b0, 1'b0),
			row_chk(OP_PUSH,   WORD_MIN, ST_OK,       0,        0, 2, 1'b0, 1'b0),
			row_chk(OP_PUSH,   ALL_ONES, ST_OK,       0,        0, 3, 1'b0, 1'b0),
			row_chk(OP_PEEK,   0,        ST_OK,       ALL_ONES, 0, 3, 1'b0, 1'b0),
			row_chk(OP_SEARCH, WORD_MIN, ST_OK,       0,        1, 3, 1'b0, 1'b0),
			row_chk(OP_SEARCH, WORD_MAX, ST_OK,       0,        0, 3, 1'b0, 1'b0),
			row_chk(OP_RSVD_5, ALL_ONES, ST_OK,       0,        0, 3, 1'b0, 1'b0),
			row_req(OP_RSVD_6, 32'h1234_5678),
			row_req(OP_RSVD_7, 0),
			row_chk(OP_POP,    0,        ST_OK,       ALL_ONES, 0, 2, 1'b0, 1'b0),
			row_cap(2),
			row_chk(OP_PUSH,   7,        ST_FULL,     0,        0, 2, 1'b0, 1'b1),
			// capacity below the count: entries stay, pushes fail
			row_cap(1),
			row_chk(OP_PUSH,   9,        ST_FULL,     0,        0, 2, 1'b0, 1'b1),
			row_chk(OP_POP,    0,        ST_OK,       WORD_MIN, 0, 1, 1'b0, 1'b1),
			row_chk(OP_POP,    0,        ST_OK,       WORD_MAX, 0, 0, 1'b1, 1'b0),
			row_cap(0),
			row_chk(OP_PUSH,   1,        ST_FULL,     0,        0, 0, 1'b1, 1'b1),
			row_chk(OP_PEEK,   0,        ST_EMPTY,    0,        0, 0, 1'b1, 1'b1),
			// beyond depth acts as depth
			row_cap(CAP_MAX),
			row_req(OP_PUSH,   0),
			row_req(OP_PUSH,   0),
			row_req(OP_PUSH,   42),
			row_req(OP_SEARCH, 0),
			row_chk(OP_CLEAR,  0,        ST_OK,       0,        0, 0, 1'b1, 1'b0),
			// stale entry above the count must not match
			row_req(OP_SEARCH, 42)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_script[r]) begin
			if (directed_script[r].is_cfg)
				write_capacity(directed_script[r].capacity);
			else
				send_request(directed_script[r].req, directed_script[r].typed,
					directed_script[r].result);
		end

		random_items = 0;
		phase_no = 0;
		burst_left = $urandom_range(1, 30);
		while (random_items < RANDOM_ITEMS) begin
			case (phase_no % 8)
				0:       begin cap_now = CAP_W'(STACK_DEPTH); mix = MIX_FILL; end
				1:       begin cap_now = CAP_MAX; mix = MIX_FILL; end
				2:       begin cap_now = CAP_W'($urandom_range(2, 12)); mix = MIX_BALANCED; end
				3:       begin cap_now = '0; mix = MIX_DRAIN; end
				4:       begin cap_now = CAP_W'(STACK_DEPTH - 1); mix = MIX_FILL; end
				5:       begin cap_now = CAP_W'(STACK_DEPTH + 1); mix = MIX_BALANCED; end
				6:       begin cap_now = CAP_W'($urandom_range(0, 511)); mix = MIX_BALANCED; end
				default: begin cap_now = 1; mix = MIX_DRAIN; end
			endcase
			write_capacity(cap_now);
			value_pool[0] = WORD_MIN;
			value_pool[1] = WORD_MAX;
			value_pool[2] = '0;
			value_pool[3] = ALL_ONES;
			for (k = 4; k < 8; k++)
				value_pool[k] = $urandom;
			phase_len = (mix == MIX_FILL) ? 340 : $urandom_range(40, 160);
			for (k = 0; k < phase_len && random_items < RANDOM_ITEMS; k++) begin
				req.operation = pick_operation(mix);
				req.value = pick_value(req.operation);
				send_request(req, 1'b0, '0);
				random_items++;
				burst_left--;
				if (burst_left == 0) begin
					gap = $urandom_range(0, 12);
					if (gap != 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
					burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
				end
			end
			phase_no++;
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (delivered_count < issued_count);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("integer_lifo_stack verification clean");
		else
			$display("integer_lifo_stack verification failed");
		$finish;
	end

endmodule
